// File: hw/rtl/text_terminal_screen_engine_macros.svh
// Assertion helpers for the checker in tte_checker.sv.
`ifndef TEXT_TERMINAL_SCREEN_ENGINE_MACROS_SVH
`define TEXT_TERMINAL_SCREEN_ENGINE_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A signal keeps its value in the cycle after the condition held.
`define TTE_HOLD(lbl, cond, sig) \
  `TTE_ASSERT(lbl, (cond) |=> $stable(sig), "value changed while held")

`endif

// File: hw/rtl/tte_pkg.sv
package tte_pkg;

  localparam int unsigned ROWS    = 32;
  localparam int unsigned COLS    = 64;
  localparam int unsigned ESC_CAP = 16;

  // The screen address is {row, col}, so both sizes are powers of two.
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned COL_W  = $clog2(COLS);
  localparam int unsigned CCOL_W = COL_W + 1;
  localparam int unsigned ADDR_W = ROW_W + COL_W;
  localparam int unsigned DEPTH  = ROWS * COLS;
  localparam int unsigned ECNT_W = $clog2(ESC_CAP);
  localparam int unsigned NUM_W  = 14;
  localparam int unsigned NUM_MAX = 9999;
  localparam int unsigned CHAR_W = 7;

  localparam logic [CHAR_W-1:0] SPACE = 7'h20;

  // Screen memory operations requested by the controller.
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_CLEAR   = 3'd1;
  localparam logic [2:0] OP_COPY_RD = 3'd2;
  localparam logic [2:0] OP_COPY_WR = 3'd3;
  localparam logic [2:0] OP_FILL    = 3'd4;
  localparam logic [2:0] OP_WRITE   = 3'd5;
  localparam logic [2:0] OP_READ    = 3'd6;

  typedef struct packed {
    logic       accept;
    logic       cnt_inc;
    logic       fill_inc;
    logic [2:0] ram_op;
    logic       cap_cell;
    logic       out_load;
  } tte_cmd_t;

  typedef struct packed {
    logic is_read;
    logic clear;
    logic scroll;
    logic fill;
    logic write;
    logic cnt_last;
    logic copy_last;
    logic fill_last;
  } tte_stat_t;

endpackage

// File: hw/rtl/tte_ram.sv
module tte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/tte_ctrl.sv
module tte_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  tte_pkg::tte_stat_t  stat_i,
  output tte_pkg::tte_cmd_t   cmd_o
);

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DISP    = 4'd2;
  localparam logic [3:0] S_READ    = 4'd3;
  localparam logic [3:0] S_RWAIT   = 4'd4;
  localparam logic [3:0] S_CLEAR   = 4'd5;
  localparam logic [3:0] S_COPY_RD = 4'd6;
  localparam logic [3:0] S_COPY_WR = 4'd7;
  localparam logic [3:0] S_BLANK   = 4'd8;
  localparam logic [3:0] S_FILL    = 4'd9;
  localparam logic [3:0] S_WRITE   = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.ram_op = tte_pkg::OP_NONE;
    case (state_q)
      S_INIT: begin
        cmd_o.ram_op  = tte_pkg::OP_CLEAR;
        cmd_o.cnt_inc = 1'b1;
        if (stat_i.cnt_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.is_read)     state_d = S_READ;
        else if (stat_i.clear)  state_d = S_CLEAR;
        else if (stat_i.scroll) state_d = S_COPY_RD;
        else if (stat_i.fill)   state_d = S_FILL;
        else if (stat_i.write)  state_d = S_WRITE;
        else                    state_d = S_DONE;
      end
      S_READ: begin
        cmd_o.ram_op = tte_pkg::OP_READ;
        state_d      = S_RWAIT;
      end
      S_RWAIT: begin
        cmd_o.cap_cell = 1'b1;
        state_d        = S_DONE;
      end
      S_CLEAR: begin
        cmd_o.ram_op  = tte_pkg::OP_CLEAR;
        cmd_o.cnt_inc = 1'b1;
        if (stat_i.cnt_last) state_d = S_DONE;
      end
      S_COPY_RD: begin
        cmd_o.ram_op = tte_pkg::OP_COPY_RD;
        state_d      = S_COPY_WR;
      end
      S_COPY_WR: begin
        cmd_o.ram_op  = tte_pkg::OP_COPY_WR;
        cmd_o.cnt_inc = 1'b1;
        state_d       = stat_i.copy_last ? S_BLANK : S_COPY_RD;
      end
      S_BLANK: begin
        cmd_o.ram_op  = tte_pkg::OP_CLEAR;
        cmd_o.cnt_inc = 1'b1;
        if (stat_i.cnt_last) state_d = stat_i.write ? S_WRITE : S_DONE;
      end
      S_FILL: begin
        cmd_o.ram_op   = tte_pkg::OP_FILL;
        cmd_o.fill_inc = 1'b1;
        if (stat_i.fill_last) state_d = S_DONE;
      end
      S_WRITE: begin
        cmd_o.ram_op = tte_pkg::OP_WRITE;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/tte_dp.sv
module tte_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               action_i,
  input  logic [7:0]         data_byte_i,
  input  logic               chunk_end_i,
  input  logic [4:0]         read_row_i,
  input  logic [5:0]         read_col_i,
  input  tte_pkg::tte_cmd_t  cmd_i,
  output tte_pkg::tte_stat_t stat_o,
  output logic [6:0]         cell_char_o,
  output logic [4:0]         cursor_row_o,
  output logic [6:0]         cursor_col_o,
  output logic               escape_pending_o,
  output logic               refresh_request_o
);

  localparam int unsigned ROW_W  = tte_pkg::ROW_W;
  localparam int unsigned COL_W  = tte_pkg::COL_W;
  localparam int unsigned CCOL_W = tte_pkg::CCOL_W;
  localparam int unsigned ADDR_W = tte_pkg::ADDR_W;
  localparam int unsigned NUM_W  = tte_pkg::NUM_W;
  localparam int unsigned ECNT_W = tte_pkg::ECNT_W;
  localparam int unsigned CHAR_W = tte_pkg::CHAR_W;

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_PLUS  = 3'd1;
  localparam logic [2:0] PH_MINUS = 3'd2;
  localparam logic [2:0] PH_NUM1  = 3'd3;
  localparam logic [2:0] PH_NEG1  = 3'd4;
  localparam logic [2:0] PH_SEMI  = 3'd5;
  localparam logic [2:0] PH_NUM2  = 3'd6;
  localparam logic [2:0] PH_BAD   = 3'd7;

  localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(tte_pkg::ROWS - 1);
  localparam logic [CCOL_W-1:0] COL_END  = CCOL_W'(tte_pkg::COLS);
  localparam logic [CCOL_W-1:0] COL_LAST = CCOL_W'(tte_pkg::COLS - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(tte_pkg::DEPTH - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(tte_pkg::DEPTH - tte_pkg::COLS - 1);

  function automatic logic [NUM_W-1:0] acc(input logic [NUM_W-1:0] v, input logic [3:0] d);
    logic [NUM_W+3:0] n;
    n = {v, 3'b000} + {3'b000, v, 1'b0} + (NUM_W+4)'(d);
    return (n > (NUM_W+4)'(tte_pkg::NUM_MAX)) ? NUM_W'(tte_pkg::NUM_MAX) : n[NUM_W-1:0];
  endfunction

  // Cursor and sequence state.
  logic [ROW_W-1:0]  row_q, row_d;
  logic [CCOL_W-1:0] col_q, col_d;
  logic              esc_q, esc_d;
  logic [ECNT_W-1:0] ecnt_q, ecnt_d;
  logic [7:0]        lead_q, lead_d;
  logic [7:0]        last_q, last_d;
  logic [2:0]        phase_q, phase_d;
  logic [NUM_W-1:0]  fv_q, fv_d;
  logic [NUM_W-1:0]  sv_q, sv_d;

  // Plan of the accepted item.
  logic              p_read_q, p_read_d;
  logic              p_clear_q, p_clear_d;
  logic              p_scroll_q, p_scroll_d;
  logic              p_fill_q, p_fill_d;
  logic              p_write_q, p_write_d;
  logic [ADDR_W-1:0] p_addr_q, p_addr_d;
  logic [CHAR_W-1:0] p_char_q, p_char_d;
  logic [ROW_W-1:0]  f_row_q, f_row_d;
  logic [CCOL_W-1:0] f_col_q;
  logic [CCOL_W-1:0] f_start_d;
  logic [CCOL_W-1:0] f_end_q, f_end_d;
  logic              refresh_q;

  logic [ADDR_W-1:0] cnt_q;
  logic [CHAR_W-1:0] cell_q;
  logic [CHAR_W-1:0] o_cell_q;
  logic [ROW_W-1:0]  o_row_q;
  logic [CCOL_W-1:0] o_col_q;
  logic              o_esc_q;
  logic              o_refresh_q;

  // Screen memory port.
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CHAR_W-1:0] wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [CHAR_W-1:0] rdata;

  always_comb begin
    logic [7:0]        b;
    logic              dig;
    logic [3:0]        d;
    logic              ws;
    logic              fin;
    logic [NUM_W-1:0]  nv;
    logic [NUM_W-1:0]  tmp;
    logic [NUM_W:0]    sum;
    logic [ROW_W:0]    r1;
    logic [CCOL_W-1:0] c1;
    logic [CCOL_W-1:0] nxt;
    b   = data_byte_i;
    dig = (b >= "0") && (b <= "9");
    d   = 4'(b - "0");
    ws  = (b == " ") || ((b >= 8'h09) && (b <= 8'h0d));
    fin = ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z")) || (b == "~") || (b == "@");
    nv  = '0;
    tmp = '0;
    sum = '0;
    r1  = '0;
    c1  = '0;
    nxt = '0;

    row_d = row_q; col_d = col_q; esc_d = esc_q; ecnt_d = ecnt_q;
    lead_d = lead_q; last_d = last_q; phase_d = phase_q; fv_d = fv_q; sv_d = sv_q;
    p_read_d = 1'b0; p_clear_d = 1'b0; p_scroll_d = 1'b0; p_fill_d = 1'b0;
    p_write_d = 1'b0;
    p_addr_d = {row_q, col_q[COL_W-1:0]};
    p_char_d = tte_pkg::SPACE;
    f_row_d = row_q; f_start_d = col_q; f_end_d = COL_END;

    if (action_i) begin
      p_read_d = (32'(read_row_i) < tte_pkg::ROWS) && (32'(read_col_i) < tte_pkg::COLS);
      p_addr_d = {ROW_W'(read_row_i), COL_W'(read_col_i)};
    end else if (esc_q) begin
      if (32'(ecnt_q) < tte_pkg::ESC_CAP - 1) begin
        if (ecnt_q == '0) begin
          lead_d = b;
        end else begin
          case (phase_q)
            PH_START: begin
              if (!ws) begin
                if (b == "+") phase_d = PH_PLUS;
                else if (b == "-") phase_d = PH_MINUS;
                else if (dig) begin fv_d = NUM_W'(d); phase_d = PH_NUM1; end
                else phase_d = PH_BAD;
              end
            end
            PH_PLUS: begin
              if (dig) begin fv_d = NUM_W'(d); phase_d = PH_NUM1; end
              else phase_d = PH_BAD;
            end
            PH_MINUS: phase_d = dig ? PH_NEG1 : PH_BAD;
            PH_NUM1: begin
              if (dig) fv_d = acc(fv_q, d);
              else phase_d = (b == ";") ? PH_SEMI : PH_BAD;
            end
            PH_NEG1: begin
              if (!dig) phase_d = (b == ";") ? PH_SEMI : PH_BAD;
            end
            PH_SEMI: begin
              if (!ws) begin
                if (b == "+") phase_d = PH_NUM2;
                else if (dig) begin sv_d = NUM_W'(d); phase_d = PH_NUM2; end
                else phase_d = PH_BAD;
              end
            end
            PH_NUM2: begin
              if (dig) sv_d = acc(sv_q, d);
              else phase_d = PH_BAD;
            end
            default: ;
          endcase
        end
        last_d = b;
        ecnt_d = ecnt_q + 1'b1;
      end
      if (fin) begin
        esc_d  = 1'b0;
        ecnt_d = '0;
        nv = (fv_d == '0) ? NUM_W'(1) : fv_d;
        if (lead_d == "[") begin
          if ((last_d == "H") || (last_d == "f")) begin
            tmp = (fv_d == '0) ? '0 : fv_d - 1'b1;
            row_d = (tmp > NUM_W'(ROW_LAST)) ? ROW_LAST : tmp[ROW_W-1:0];
            tmp = (sv_d == '0) ? '0 : sv_d - 1'b1;
            col_d = (tmp > NUM_W'(COL_LAST)) ? COL_LAST : tmp[CCOL_W-1:0];
          end else if (last_d == "J") begin
            p_clear_d = 1'b1;
            row_d = '0;
            col_d = '0;
          end else if (last_d == "K") begin
            p_fill_d = (col_q < COL_END);
          end else if (last_d == "A") begin
            row_d = (nv >= NUM_W'(row_q)) ? '0 : row_q - nv[ROW_W-1:0];
          end else if (last_d == "B") begin
            sum = (NUM_W+1)'(row_q) + (NUM_W+1)'(nv);
            row_d = (sum > (NUM_W+1)'(ROW_LAST)) ? ROW_LAST : sum[ROW_W-1:0];
          end else if (last_d == "C") begin
            sum = (NUM_W+1)'(col_q) + (NUM_W+1)'(nv);
            col_d = (sum > (NUM_W+1)'(COL_LAST)) ? COL_LAST : sum[CCOL_W-1:0];
          end else if (last_d == "D") begin
            col_d = (nv >= NUM_W'(col_q)) ? '0 : col_q - nv[CCOL_W-1:0];
          end
        end
      end
    end else if (b == 8'h1b) begin
      esc_d = 1'b1; ecnt_d = '0; lead_d = '0; last_d = '0;
      phase_d = PH_START; fv_d = '0; sv_d = '0;
    end else if (b == 8'h0d) begin
      col_d = '0;
    end else if (b == 8'h0a) begin
      r1 = {1'b0, row_q} + 1'b1;
      if (r1 > (ROW_W+1)'(ROW_LAST)) begin
        p_scroll_d = 1'b1;
        row_d = ROW_LAST;
      end else begin
        row_d = r1[ROW_W-1:0];
      end
    end else if (b == 8'h08) begin
      if (col_q != '0) begin
        col_d = col_q - 1'b1;
        p_write_d = 1'b1;
        p_addr_d = {row_q, col_d[COL_W-1:0]};
      end
    end else if (b == 8'h09) begin
      nxt = (col_q + CCOL_W'(8)) & ~CCOL_W'(7);
      if (col_q < COL_END) begin
        col_d = nxt;
        p_fill_d = 1'b1;
        f_end_d = nxt;
      end
    end else if ((b >= 8'h20) && (b < 8'h7f)) begin
      r1 = {1'b0, row_q};
      c1 = col_q;
      if (col_q >= COL_END) begin
        c1 = '0;
        r1 = r1 + 1'b1;
      end
      if (r1 > (ROW_W+1)'(ROW_LAST)) begin
        p_scroll_d = 1'b1;
        r1 = (ROW_W+1)'(ROW_LAST);
      end
      row_d = r1[ROW_W-1:0];
      col_d = c1 + 1'b1;
      p_write_d = 1'b1;
      p_addr_d = {r1[ROW_W-1:0], c1[COL_W-1:0]};
      p_char_d = b[CHAR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0; col_q <= '0; esc_q <= 1'b0; ecnt_q <= '0;
      lead_q <= '0; last_q <= '0; phase_q <= PH_START; fv_q <= '0; sv_q <= '0;
      cnt_q <= '0;
      p_read_q <= 1'b0; p_clear_q <= 1'b0; p_scroll_q <= 1'b0;
      p_fill_q <= 1'b0; p_write_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        row_q <= row_d; col_q <= col_d; esc_q <= esc_d; ecnt_q <= ecnt_d;
        lead_q <= lead_d; last_q <= last_d; phase_q <= phase_d;
        fv_q <= fv_d; sv_q <= sv_d;
        p_read_q <= p_read_d; p_clear_q <= p_clear_d; p_scroll_q <= p_scroll_d;
        p_fill_q <= p_fill_d; p_write_q <= p_write_d;
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      p_addr_q  <= p_addr_d;
      p_char_q  <= p_char_d;
      f_row_q   <= f_row_d;
      f_col_q   <= f_start_d;
      f_end_q   <= f_end_d;
      refresh_q <= !action_i && chunk_end_i;
      cell_q    <= '0;
    end else begin
      if (cmd_i.fill_inc) f_col_q <= f_col_q + 1'b1;
      if (cmd_i.cap_cell) cell_q <= rdata;
    end
    if (cmd_i.out_load) begin
      o_cell_q    <= cell_q;
      o_row_q     <= row_q;
      o_col_q     <= col_q;
      o_esc_q     <= esc_q;
      o_refresh_q <= refresh_q;
    end
  end

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = cnt_q;
    wdata = tte_pkg::SPACE;
    raddr = cnt_q + ADDR_W'(tte_pkg::COLS);
    case (cmd_i.ram_op)
      tte_pkg::OP_CLEAR:   we = 1'b1;
      tte_pkg::OP_COPY_RD: re = 1'b1;
      tte_pkg::OP_COPY_WR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      tte_pkg::OP_FILL: begin
        we    = 1'b1;
        waddr = {f_row_q, f_col_q[COL_W-1:0]};
      end
      tte_pkg::OP_WRITE: begin
        we    = 1'b1;
        waddr = p_addr_q;
        wdata = p_char_q;
      end
      tte_pkg::OP_READ: begin
        re    = 1'b1;
        raddr = p_addr_q;
      end
      default: ;
    endcase
  end

  tte_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(tte_pkg::DEPTH)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign stat_o.is_read   = p_read_q;
  assign stat_o.clear     = p_clear_q;
  assign stat_o.scroll    = p_scroll_q;
  assign stat_o.fill      = p_fill_q;
  assign stat_o.write     = p_write_q;
  assign stat_o.cnt_last  = (cnt_q == ADDR_LAST);
  assign stat_o.copy_last = (cnt_q == COPY_LAST);
  assign stat_o.fill_last = ((f_col_q + 1'b1) >= f_end_q);

  assign cell_char_o       = 7'(o_cell_q);
  assign cursor_row_o      = 5'(o_row_q);
  assign cursor_col_o      = 7'(o_col_q);
  assign escape_pending_o  = o_esc_q;
  assign refresh_request_o = o_refresh_q;

endmodule

// File: hw/rtl/text_terminal_screen_engine.sv
// Character screen engine for a small VT100-style terminal.
// The input stream carries one item per transfer: tuser selects a received
// byte (0) or a cell read (1); tlast marks the last byte of a received chunk.
// Every input transfer yields exactly one output transfer with the read cell,
// the cursor after the item, the escape-pending flag and, on tlast of a
// received byte, the request to redraw the screen.
// Steps per item: plain bytes, cursor moves and escape bytes touch no cell;
// a character or backspace writes one cell; a cell read goes through the
// registered read port of the screen memory; tab and erase-to-end-of-line
// write the cleared cells one at a time; a scroll copies the screen up one
// row, reading and writing cell by cell, and blanks the last row; a clear
// screen blanks every cell.
// s_axis_tready rises again together with m_axis_tvalid, so a new item is
// taken only once the result of the last one is in the output register.
// The screen memory has one write port and one registered read port.
// After reset the block clears the whole screen memory with s_axis_tready
// low, then takes items.
// The output register holds a result while the receiver stalls; the next
// item is taken meanwhile and waits in its last step until the register frees.
module text_terminal_screen_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // data_byte [7:0], read_row [12:8], read_col [18:13], zero [23:19]
  input  logic [23:0] s_axis_tdata,
  // action
  input  logic        s_axis_tuser,
  // chunk_end
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cell_char [6:0], cursor_row [11:7], cursor_col [18:12],
  // escape_pending [19], zero [23:20]
  output logic [23:0] m_axis_tdata,
  // refresh_request
  output logic        m_axis_tlast
);

  tte_pkg::tte_cmd_t  cmd;
  tte_pkg::tte_stat_t stat;

  logic [6:0] cell_char;
  logic [4:0] cursor_row;
  logic [6:0] cursor_col;
  logic       escape_pending;

  // Sequencer: accepts items and walks the screen memory operations.
  tte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Byte decoder, cursor, escape parser, screen memory and output register.
  tte_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .action_i         (s_axis_tuser),
    .data_byte_i      (s_axis_tdata[7:0]),
    .chunk_end_i      (s_axis_tlast),
    .read_row_i       (s_axis_tdata[12:8]),
    .read_col_i       (s_axis_tdata[18:13]),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cell_char_o      (cell_char),
    .cursor_row_o     (cursor_row),
    .cursor_col_o     (cursor_col),
    .escape_pending_o (escape_pending),
    .refresh_request_o(m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, escape_pending, cursor_col, cursor_row, cell_char};

endmodule

// File: hw/rtl/tte_checker.sv
`include "text_terminal_screen_engine_macros.svh"

module tte_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  `TTE_ASSERT(a_out_valid_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output valid dropped while stalled")
  `TTE_HOLD(a_out_data_holds, m_axis_tvalid && !m_axis_tready, m_axis_tdata)
  `TTE_ASSERT(a_busy_after_take, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "item taken while busy")
  `TTE_ASSERT(a_col_range, m_axis_tvalid |-> m_axis_tdata[18:12] <= 7'd64 && m_axis_tdata[23:20] == 4'd0, "cursor column or padding out of range")

endmodule

bind text_terminal_screen_engine tte_checker u_tte_checker (.*);

// File: bench/text_terminal_screen_engine_chk.sv
`timescale 1ns / 1ps

module text_terminal_screen_engine_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_cnt_o,
  output int          pending_o
);

  localparam logic [7:0] CH_ESC = 8'h1b;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_DEL = 8'h7f;

  localparam int ROWS    = tte_pkg::ROWS;
  localparam int COLS    = tte_pkg::COLS;
  localparam int ESC_CAP = tte_pkg::ESC_CAP;
  localparam int NUM_MAX = tte_pkg::NUM_MAX;

  typedef enum int {
    NP_START, NP_PLUS, NP_MINUS, NP_FIRST, NP_NEG, NP_SEMI, NP_SECOND, NP_BAD
  } num_phase_e;

  typedef struct packed {
    logic [6:0] chr;
    logic [4:0] row;
    logic [6:0] col;
    logic       esc;
    logic       refresh;
  } screen_result_t;

  logic [6:0]  screen [ROWS][COLS];
  int          crow, ccol;
  logic        esc_on;
  int          esc_len;
  logic [7:0]  esc_lead, esc_final;
  num_phase_e  nphase;
  int          num_a, num_b;
  screen_result_t expected_q[$];

  assign pending_o = expected_q.size();

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_cnt_o++;
  endtask

  function automatic int sat_acc(input int v, input int d);
    int n;
    n = v * 10 + d;
    return (n > NUM_MAX) ? NUM_MAX : n;
  endfunction

  function automatic bit is_space(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  task automatic blank_all();
    foreach (screen[r, c]) screen[r][c] = tte_pkg::SPACE;
    crow = 0;
    ccol = 0;
  endtask

  task automatic scroll();
    for (int r = 0; r < ROWS - 1; r++)
      for (int c = 0; c < COLS; c++) screen[r][c] = screen[r + 1][c];
    for (int c = 0; c < COLS; c++) screen[ROWS - 1][c] = tte_pkg::SPACE;
    crow = ROWS - 1;
  endtask

  task automatic parse_num(input logic [7:0] b);
    bit dig;
    int d;
    dig = b >= "0" && b <= "9";
    d = int'(b) - int'("0");
    case (nphase)
      NP_START: begin
        if (!is_space(b)) begin
          if (b == "+") nphase = NP_PLUS;
          else if (b == "-") nphase = NP_MINUS;
          else if (dig) begin num_a = d; nphase = NP_FIRST; end
          else nphase = NP_BAD;
        end
      end
      NP_PLUS: begin
        if (dig) begin num_a = d; nphase = NP_FIRST; end
        else nphase = NP_BAD;
      end
      NP_MINUS: nphase = dig ? NP_NEG : NP_BAD;
      NP_FIRST: begin
        if (dig) num_a = sat_acc(num_a, d);
        else nphase = (b == ";") ? NP_SEMI : NP_BAD;
      end
      NP_NEG: begin
        if (!dig) nphase = (b == ";") ? NP_SEMI : NP_BAD;
      end
      NP_SEMI: begin
        if (!is_space(b)) begin
          if (b == "+") nphase = NP_SECOND;
          else if (dig) begin num_b = d; nphase = NP_SECOND; end
          else nphase = NP_BAD;
        end
      end
      NP_SECOND: begin
        if (dig) num_b = sat_acc(num_b, d);
        else nphase = NP_BAD;
      end
      default: ;
    endcase
  endtask

  task automatic run_command();
    int n;
    n = (num_a < 1) ? 1 : num_a;
    if (esc_lead == "[") begin
      case (esc_final)
        "H", "f": begin
          crow = (num_a > 0) ? num_a - 1 : 0;
          ccol = (num_b > 0) ? num_b - 1 : 0;
          if (crow > ROWS - 1) crow = ROWS - 1;
          if (ccol > COLS - 1) ccol = COLS - 1;
        end
        "J": blank_all();
        "K": for (int c = ccol; c < COLS; c++) screen[crow][c] = tte_pkg::SPACE;
        "A": crow = (n >= crow) ? 0 : crow - n;
        "B": crow = (crow + n > ROWS - 1) ? ROWS - 1 : crow + n;
        "C": ccol = (ccol + n > COLS - 1) ? COLS - 1 : ccol + n;
        "D": ccol = (n >= ccol) ? 0 : ccol - n;
        default: ;
      endcase
    end
  endtask

  task automatic apply_byte(input logic [7:0] b);
    int stop;
    if (esc_on) begin
      if (esc_len < ESC_CAP - 1) begin
        if (esc_len == 0) esc_lead = b;
        else parse_num(b);
        esc_final = b;
        esc_len++;
      end
      if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "~" || b == "@") begin
        run_command();
        esc_on = 1'b0;
        esc_len = 0;
      end
    end else if (b == CH_ESC) begin
      esc_on = 1'b1;
      esc_len = 0;
      esc_lead = '0;
      esc_final = '0;
      nphase = NP_START;
      num_a = 0;
      num_b = 0;
    end else if (b == CH_CR) begin
      ccol = 0;
    end else if (b == CH_LF) begin
      crow++;
      if (crow >= ROWS) scroll();
    end else if (b == CH_BS) begin
      if (ccol > 0) begin
        ccol--;
        screen[crow][ccol] = tte_pkg::SPACE;
      end
    end else if (b == CH_TAB) begin
      stop = (ccol + 8) & ~7;
      while (ccol < stop && ccol < COLS) begin
        screen[crow][ccol] = tte_pkg::SPACE;
        ccol++;
      end
    end else if (b >= 8'h20 && b < CH_DEL) begin
      if (ccol >= COLS) begin
        ccol = 0;
        crow++;
      end
      if (crow >= ROWS) scroll();
      screen[crow][ccol] = b[6:0];
      ccol++;
    end
  endtask

  screen_result_t got, want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_all();
      esc_on = 1'b0;
      esc_len = 0;
      esc_lead = '0;
      esc_final = '0;
      nphase = NP_START;
      num_a = 0;
      num_b = 0;
      expected_q.delete();
      fail_cnt_o = 0;
    end else begin
      // Output side first: an item taken in this cycle cannot have its result yet.
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[6:0], m_axis_tdata[11:7], m_axis_tdata[18:12],
               m_axis_tdata[19], m_axis_tlast};
        if (expected_q.size() == 0) begin
          report("unexpected transfer", int'(m_axis_tdata), -1);
        end else begin
          want = expected_q.pop_front();
          if (got.chr != want.chr) report("cell_char", int'(got.chr), int'(want.chr));
          if (got.row != want.row) report("cursor_row", int'(got.row), int'(want.row));
          if (got.col != want.col) report("cursor_col", int'(got.col), int'(want.col));
          if (got.esc != want.esc) report("escape_pending", int'(got.esc), int'(want.esc));
          if (got.refresh != want.refresh) begin
            report("refresh_request", int'(got.refresh), int'(want.refresh));
          end
          if (m_axis_tdata[23:20] != '0) report("pad bits", int'(m_axis_tdata[23:20]), 0);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = '0;
        if (!s_axis_tuser) begin
          apply_byte(s_axis_tdata[7:0]);
          want.refresh = s_axis_tlast;
        end else begin
          want.chr = screen[s_axis_tdata[12:8]][s_axis_tdata[18:13]];
        end
        want.row = crow[4:0];
        want.col = ccol[6:0];
        want.esc = esc_on;
        expected_q.push_back(want);
      end
    end
  end

endmodule

// File: bench/text_terminal_screen_engine_tb.sv
`timescale 1ns / 1ps

module text_terminal_screen_engine_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          fail_cnt, pending;
  int          sent_cnt = 0;
  bit          idle_en = 1'b1;

  localparam logic [7:0] CH_ESC = 8'h1b;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam bit ACT_BYTE = 1'b0;
  localparam bit ACT_READ = 1'b1;

  always #10 clk_i = ~clk_i;

  text_terminal_screen_engine i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  text_terminal_screen_engine_chk i_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one item and returns after its transfer. Valid stays high across
  // back-to-back items; it only drops when a gap is taken.
  task automatic send_item(input bit act, input logic [7:0] b, input bit last,
                           input logic [4:0] row, input logic [5:0] col);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {5'd0, col, row, b};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_cnt++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(ACT_BYTE, b, $urandom_range(0, 3) == 0, 5'($urandom), 6'($urandom));
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic read_cell(input logic [4:0] row, input logic [5:0] col);
    send_item(ACT_READ, 8'($urandom), 1'($urandom_range(0, 1)), row, col);
  endtask

  // A well-formed control sequence with random numbers and a random final byte.
  task automatic send_csi();
    string fin;
    int r;
    send_byte(CH_ESC);
    send_byte("[");
    if ($urandom_range(0, 4) == 0) send_byte(" ");
    r = $urandom_range(0, 9);
    if (r == 0) send_byte("-");
    else if (r == 1) send_byte("+");
    repeat ($urandom_range(0, 3)) send_byte(8'("0" + $urandom_range(0, 9)));
    if ($urandom_range(0, 1)) begin
      send_byte(";");
      if ($urandom_range(0, 5) == 0) send_byte("+");
      repeat ($urandom_range(0, 3)) send_byte(8'("0" + $urandom_range(0, 9)));
    end
    fin = "HfJKABCDHfKABCDxm~@";
    // Clears are costly, so J is picked only now and then.
    r = $urandom_range(0, fin.len() - 1);
    if (fin[r] == "J" && $urandom_range(0, 3) != 0) r = 0;
    send_byte(fin[r]);
  endtask

  // The receiver stalls at random, and once holds off for a long stretch
  // while the sender keeps offering, so the block fills up.
  initial begin
    int hold;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && sent_cnt >= 150) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        hold = 0;
        while (hold < 3000) begin
          @(posedge clk_i);
          hold++;
        end
      end
      if (idle_en && $urandom_range(0, 49) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end else begin
        m_axis_tready <= !idle_en || ($urandom_range(0, 99) < 70);
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: extremes, overlong and malformed sequences, clamps.
    read_cell(5'd31, 6'd63);
    send_text("~ ");
    send_byte(CH_TAB);
    send_byte(CH_BS);
    send_byte(8'hff);
    send_byte(CH_CR);
    send_text({8'h1b, "[99999;77777H"});
    send_text({8'h1b, "[-5A"});
    send_text({8'h1b, "[C"});
    send_byte("Z");
    send_byte(CH_TAB);
    send_text({8'h1b, "[K"});
    send_byte(CH_LF);
    send_text({8'h1b, "[1;1;5;5;5;5;5;5H"});
    send_text({8'h1b, "(B"});
    send_text({8'h1b, "[2J"});
    read_cell(5'd0, 6'd0);

    // Random part: mostly text and well-formed sequences, some noise.
    for (int i = 0; i < 245; i++) begin
      if (i % 120 == 60) idle_en = 1'b0;
      if (i % 120 == 90) idle_en = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 20) read_cell(5'($urandom), 6'($urandom));
      else if (r < 50) send_byte(8'($urandom_range(8'h20, 8'h7e)));
      else if (r < 62) send_csi();
      else if (r < 66) send_byte(CH_LF);
      else if (r < 69) send_byte(CH_CR);
      else if (r < 72) send_byte(CH_BS);
      else if (r < 75) send_byte(CH_TAB);
      else if (r < 85) send_byte(8'($urandom));
      else if (r < 87) begin
        send_byte(CH_ESC);
        repeat ($urandom_range(14, 20)) send_byte(8'("0" + $urandom_range(0, 9)));
        send_byte("H");
      end else if (r < 88) begin
        send_text({8'h1b, "[99B"});
        send_byte(CH_LF);
      end else begin
        read_cell(5'($urandom), 6'($urandom));
      end
    end
    s_axis_tvalid <= 1'b0;
    idle_en = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) $display("text_terminal_screen_engine_tb OK");
    else $display("text_terminal_screen_engine_tb NOT OK");
    $finish;
  end

  initial begin
    #250ms;
    $display("text_terminal_screen_engine_tb NOT OK");
    $finish;
  end

endmodule
